// ===== rtl/rtns_pkg.sv =====
`timescale 1ns / 1ps

package rtns_pkg;

  // Default texture store dimensions
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Texel layout: red in the low channel, blue in the high channel
  localparam int CHANNEL_BITS = 8;
  localparam int NUM_CHANNELS = 3;
  localparam int TEXEL_W      = NUM_CHANNELS * CHANNEL_BITS;

  // Field widths of the channels
  localparam int CMD_W         = 1;
  localparam int COORD_W       = 16;
  localparam int REGION_POS_W  = 8;
  localparam int REGION_SIZE_W = 9;
  localparam int STATUS_W      = 2;
  localparam int CFG_DATA_W    = 9;
  localparam int CFG_INDEX_W   = 2;

  // Q3.12 coordinates: integer bits bound the wrap quotient, fraction bits are dropped
  localparam int FRAC_BITS   = 12;
  localparam int INT_BITS    = 3;
  localparam int QUOT_STEPS  = INT_BITS + 1;

  // Size registers after reset
  localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = CFG_DATA_W'(256);

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

  // Commands
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_SAMPLED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_WRITTEN  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_FIX,
    ST_WCHK,
    ST_ADDR,
    ST_ACCESS,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/rtns_cfg_if.sv =====
`timescale 1ns / 1ps

interface rtns_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rtns_pkg::CFG_INDEX_W-1:0]   index;
  logic [rtns_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rtns_item_if.sv =====
`timescale 1ns / 1ps

interface rtns_item_if;
  logic                                   valid;
  logic                                   ready;
  logic [rtns_pkg::CMD_W-1:0]             cmd;
  logic signed [rtns_pkg::COORD_W-1:0]    coord_u;
  logic signed [rtns_pkg::COORD_W-1:0]    coord_v;
  logic [rtns_pkg::REGION_POS_W-1:0]      region_x;
  logic [rtns_pkg::REGION_POS_W-1:0]      region_y;
  logic [rtns_pkg::REGION_SIZE_W-1:0]     region_w;
  logic [rtns_pkg::REGION_SIZE_W-1:0]     region_h;
  logic [rtns_pkg::CHANNEL_BITS-1:0]      in_red;
  logic [rtns_pkg::CHANNEL_BITS-1:0]      in_green;
  logic [rtns_pkg::CHANNEL_BITS-1:0]      in_blue;
  logic                                   region_last;

  modport source (
    output valid, output cmd, output coord_u, output coord_v,
    output region_x, output region_y, output region_w, output region_h,
    output in_red, output in_green, output in_blue, output region_last,
    input ready
  );
  modport sink (
    input valid, input cmd, input coord_u, input coord_v,
    input region_x, input region_y, input region_w, input region_h,
    input in_red, input in_green, input in_blue, input region_last,
    output ready
  );
endinterface

// ===== rtl/rtns_result_if.sv =====
`timescale 1ns / 1ps

interface rtns_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [rtns_pkg::CHANNEL_BITS-1:0]    out_red;
  logic [rtns_pkg::CHANNEL_BITS-1:0]    out_green;
  logic [rtns_pkg::CHANNEL_BITS-1:0]    out_blue;
  logic [rtns_pkg::STATUS_W-1:0]        status;

  modport source (
    output valid, output out_red, output out_green, output out_blue, output status,
    input ready
  );
  modport sink (
    input valid, input out_red, input out_green, input out_blue, input status,
    output ready
  );
endinterface

// ===== rtl/rtns_ram.sv =====
`timescale 1ns / 1ps

module rtns_ram #(
  parameter int WIDTH = rtns_pkg::TEXEL_W,
  parameter int DEPTH = rtns_pkg::MAX_WIDTH_DEF * rtns_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rgb_texture_nearest_sampler.sv =====
`timescale 1ns / 1ps

// RGB texel store with nearest-neighbor sampling and wrap-around addressing.
// cfg:    register writes (index 0 image width, index 1 image height); always ready.
//         Write only while no transaction is in flight.
// item:   cmd 0 samples at signed Q3.12 (coord_u, coord_v); cmd 1 stores one texel
//         of a region given by region_x/y/w/h, texels in raster order.
// result: one transaction per item: sampled RGB and status (0 sampled, 1 written,
//         2 rejected because the region is empty or overruns the image).
// Timing: one item at a time; item.ready is high only while the sequencer idles.
//   Sample: each axis passes through the shared multiplier and the 4-step
//   shift-subtract remainder unit (MUL, ABS, DIV, FIX); the texel address then
//   reuses the multiplier (row * width) in ADDR before ACCESS and DONE.
//   Write: WCHK, ADDR, ACCESS, DONE; a rejected write goes from WCHK to DONE.
// Reset: the store is cleared one texel per cycle, all MAX_WIDTH * MAX_HEIGHT texels
//   (65536 by default); items are not taken meanwhile, cfg writes are.
// Stall: a finished result waits in the output register; the next item is taken
//   and processed, and holds in its last state until the register is free.
module rgb_texture_nearest_sampler #(
  parameter int MAX_WIDTH  = rtns_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rtns_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rtns_cfg_if.sink    cfg,
  rtns_item_if.sink   item,
  rtns_result_if.source result
);

  import rtns_pkg::*;

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int DIM_W   = (XW > YW) ? XW : YW;
  localparam int SZ_W    = DIM_W + 1;
  localparam int MW      = DIM_W + INT_BITS;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int MUL_A_W = COORD_W + 1;
  localparam int PW      = MUL_A_W + SZ_W + 1;
  localparam int SUM_W   = ((SZ_W > REGION_SIZE_W) ? SZ_W : REGION_SIZE_W) + 2;
  localparam int STEP_W  = $clog2(QUOT_STEPS);

  // Control state
  state_t                  state;
  state_t                  state_next;
  logic [AW-1:0]           clear_addr;
  logic [CFG_DATA_W-1:0]   cfg_width;
  logic [CFG_DATA_W-1:0]   cfg_height;
  logic [XW-1:0]           write_col;
  logic [YW-1:0]           write_row;
  logic                    out_valid;

  // Captured item
  logic [CMD_W-1:0]          cmd_q;
  logic signed [COORD_W-1:0] coord_u_q;
  logic signed [COORD_W-1:0] coord_v_q;
  logic [REGION_POS_W-1:0]   region_x_q;
  logic [REGION_POS_W-1:0]   region_y_q;
  logic [REGION_SIZE_W-1:0]  region_w_q;
  logic [REGION_SIZE_W-1:0]  region_h_q;
  logic [TEXEL_W-1:0]        texel_q;
  logic                      last_q;

  // Working registers
  logic                    axis_v;
  logic signed [PW-1:0]    prod;
  logic [MW-1:0]           mag;
  logic                    neg;
  logic [STEP_W-1:0]       step;
  logic [DIM_W-1:0]        x_idx;
  logic [DIM_W-1:0]        y_idx;
  logic                    reject_q;

  // Output register
  logic [CHANNEL_BITS-1:0] out_red;
  logic [CHANNEL_BITS-1:0] out_green;
  logic [CHANNEL_BITS-1:0] out_blue;
  logic [STATUS_W-1:0]     out_status;

  // Sequencer strobes
  logic item_ready;
  logic ram_we;
  logic ram_re;
  logic load_result;

  // Datapath wires
  logic [SZ_W-1:0]          w_eff;
  logic [SZ_W-1:0]          h_eff;
  logic [SZ_W-1:0]          span_sel;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [SZ_W:0]     mul_b;
  logic signed [PW-1:0]     mul_p;
  logic [PW-1:0]            prod_abs;
  logic [MW:0]              div_shift;
  logic [MW:0]              div_trial;
  logic [DIM_W-1:0]         idx_fix;
  logic                     reject;
  logic                     restart;
  logic [SUM_W-1:0]         col_sel;
  logic [SUM_W-1:0]         row_sel;
  logic [SUM_W-1:0]         col_inc;
  logic [SUM_W-1:0]         row_inc;
  logic [SUM_W-1:0]         col_new;
  logic [SUM_W-1:0]         row_new;
  logic [SUM_W-1:0]         x_sum;
  logic [SUM_W-1:0]         y_sum;
  logic [AW-1:0]            access_addr;
  logic [AW-1:0]            ram_waddr;
  logic [TEXEL_W-1:0]       ram_wdata;
  logic [TEXEL_W-1:0]       ram_rdata;

  // Clamp configured sizes into 1..MAX
  always_comb begin
    if (cfg_width == '0) begin
      w_eff = SZ_W'(1);
    end else if (int'(cfg_width) > MAX_WIDTH) begin
      w_eff = SZ_W'(MAX_WIDTH);
    end else begin
      w_eff = SZ_W'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_eff = SZ_W'(1);
    end else if (int'(cfg_height) > MAX_HEIGHT) begin
      h_eff = SZ_W'(MAX_HEIGHT);
    end else begin
      h_eff = SZ_W'(cfg_height);
    end
  end

  assign span_sel = axis_v ? (h_eff - SZ_W'(1)) : (w_eff - SZ_W'(1));

  // Shared multiplier: coordinate times span, or row times width
  always_comb begin
    if (state == ST_ADDR) begin
      mul_a = $signed({{(MUL_A_W - DIM_W){1'b0}}, y_idx});
      mul_b = $signed({1'b0, w_eff});
    end else begin
      mul_a = axis_v ? MUL_A_W'(coord_v_q) : MUL_A_W'(coord_u_q);
      mul_b = $signed({1'b0, span_sel});
    end
  end
  assign mul_p = mul_a * mul_b;

  // Truncate toward zero: magnitude of the product, fraction dropped
  assign prod_abs = prod[PW-1] ? PW'(-prod) : PW'(prod);

  // Shared shift-subtract step of the remainder unit
  assign div_shift = {{(MW + 1 - SZ_W){1'b0}}, span_sel} << step;
  assign div_trial = {1'b0, mag} - div_shift;

  // Negative remainder is lifted by the span
  assign idx_fix = (neg && (mag != '0)) ? (span_sel[DIM_W-1:0] - mag[DIM_W-1:0])
                                        : mag[DIM_W-1:0];

  // Region checks and raster counters
  always_comb begin
    reject = (region_w_q == '0) || (region_h_q == '0) ||
             (SUM_W'(region_x_q) + SUM_W'(region_w_q) > SUM_W'(w_eff)) ||
             (SUM_W'(region_y_q) + SUM_W'(region_h_q) > SUM_W'(h_eff));
    restart = (SUM_W'(write_col) >= SUM_W'(region_w_q)) ||
              (SUM_W'(write_row) >= SUM_W'(region_h_q));
    col_sel = restart ? '0 : SUM_W'(write_col);
    row_sel = restart ? '0 : SUM_W'(write_row);
    col_inc = col_sel + SUM_W'(1);
    row_inc = row_sel + SUM_W'(1);
    if (col_inc >= SUM_W'(region_w_q)) begin
      col_new = '0;
      row_new = (row_inc >= SUM_W'(region_h_q)) ? '0 : row_inc;
    end else begin
      col_new = col_inc;
      row_new = row_sel;
    end
    x_sum = SUM_W'(region_x_q) + col_sel;
    y_sum = SUM_W'(region_y_q) + row_sel;
  end

  // Texel address: row product plus column
  assign access_addr = prod[AW-1:0] + AW'(x_idx);
  assign ram_waddr   = (state == ST_CLEAR) ? clear_addr : access_addr;
  assign ram_wdata   = (state == ST_CLEAR) ? '0 : texel_q;

  // Sequencer: next state and strobes
  always_comb begin
    state_next  = state;
    item_ready  = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    load_result = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clear_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item.valid) begin
          state_next = (item.cmd == CMD_WRITE) ? ST_WCHK : ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_ABS;
      end
      ST_ABS: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (step == '0) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        state_next = axis_v ? ST_ADDR : ST_MUL;
      end
      ST_WCHK: begin
        state_next = reject ? ST_DONE : ST_ADDR;
      end
      ST_ADDR: begin
        state_next = ST_ACCESS;
      end
      ST_ACCESS: begin
        ram_we     = (cmd_q == CMD_WRITE);
        ram_re     = (cmd_q == CMD_SAMPLE);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        load_result = !out_valid || result.ready;
        if (load_result) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + AW'(1);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= CFG_SIZE_RESET;
      cfg_height <= CFG_SIZE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_IMAGE_WIDTH:  cfg_width  <= cfg.data;
        CFG_IMAGE_HEIGHT: cfg_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Raster counters advance on each write item that is not rejected; a last item resets them
  always_ff @(posedge clk) begin
    if (rst) begin
      write_col <= '0;
      write_row <= '0;
    end else if (state == ST_WCHK) begin
      if (last_q) begin
        write_col <= '0;
        write_row <= '0;
      end else if (!reject) begin
        write_col <= col_new[XW-1:0];
        write_row <= row_new[YW-1:0];
      end
    end
  end

  // Capture the item and run the datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item.valid) begin
          cmd_q      <= item.cmd;
          coord_u_q  <= item.coord_u;
          coord_v_q  <= item.coord_v;
          region_x_q <= item.region_x;
          region_y_q <= item.region_y;
          region_w_q <= item.region_w;
          region_h_q <= item.region_h;
          texel_q    <= {item.in_blue, item.in_green, item.in_red};
          last_q     <= item.region_last;
          axis_v     <= 1'b0;
        end
      end
      ST_MUL: begin
        prod <= mul_p;
      end
      ST_ABS: begin
        mag  <= prod_abs[FRAC_BITS +: MW];
        neg  <= prod[PW-1];
        step <= STEP_W'(QUOT_STEPS - 1);
      end
      ST_DIV: begin
        if (!div_trial[MW]) begin
          mag <= div_trial[MW-1:0];
        end
        step <= step - STEP_W'(1);
      end
      ST_FIX: begin
        if (axis_v) begin
          y_idx <= idx_fix;
        end else begin
          x_idx <= idx_fix;
        end
        axis_v <= 1'b1;
      end
      ST_WCHK: begin
        reject_q <= reject;
        x_idx    <= x_sum[DIM_W-1:0];
        y_idx    <= y_sum[DIM_W-1:0];
      end
      ST_ADDR: begin
        prod <= mul_p;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      if (cmd_q == CMD_SAMPLE) begin
        out_red    <= ram_rdata[0 +: CHANNEL_BITS];
        out_green  <= ram_rdata[CHANNEL_BITS +: CHANNEL_BITS];
        out_blue   <= ram_rdata[2 * CHANNEL_BITS +: CHANNEL_BITS];
        out_status <= STATUS_SAMPLED;
      end else begin
        out_red    <= '0;
        out_green  <= '0;
        out_blue   <= '0;
        out_status <= reject_q ? STATUS_REJECTED : STATUS_WRITTEN;
      end
    end
  end

  // Texel store
  rtns_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (access_addr),
    .rdata (ram_rdata)
  );

  // Drive the channels
  assign cfg.ready        = 1'b1;
  assign item.ready       = item_ready;
  assign result.valid     = out_valid;
  assign result.out_red   = out_red;
  assign result.out_green = out_green;
  assign result.out_blue  = out_blue;
  assign result.status    = out_status;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rtns_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned Q_ONE       = 1 << FRAC_BITS;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [COORD_W-1:0]       coord_u;
    logic [COORD_W-1:0]       coord_v;
    logic [REGION_POS_W-1:0]  region_x;
    logic [REGION_POS_W-1:0]  region_y;
    logic [REGION_SIZE_W-1:0] region_w;
    logic [REGION_SIZE_W-1:0] region_h;
    logic [CHANNEL_BITS-1:0]  in_red;
    logic [CHANNEL_BITS-1:0]  in_green;
    logic [CHANNEL_BITS-1:0]  in_blue;
    logic                     region_last;
  } sampler_req_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [STATUS_W-1:0]     status;
  } texel_result_t;

  logic clk;
  logic rst;

  rtns_cfg_if    cfg_bus ();
  rtns_item_if   item_bus ();
  rtns_result_if result_bus ();

  rgb_texture_nearest_sampler u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .item   (item_bus),
    .result (result_bus)
  );

  // Mirror of the block: size registers, fill counters and texel store
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  int unsigned           fill_col;
  int unsigned           fill_row;
  logic [TEXEL_W-1:0]    texel_mem [STORE_DEPTH];
  texel_result_t         expected_q [$];

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_len;
  bit          hold_pending;
  int unsigned error_count;
  int unsigned cycle_count;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Drive result ready: random stalls, or a long hold-off when requested
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk);
      end else begin
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each result transaction against the oldest expected texel
  always @(posedge clk) begin
    texel_result_t exp_res;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d status %0d",
               result_bus.out_red, result_bus.out_green, result_bus.out_blue,
               result_bus.status);
        error_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (result_bus.out_red !== exp_res.red) begin
          $error("out_red: expected %0d, got %0d", exp_res.red, result_bus.out_red);
          error_count++;
        end
        if (result_bus.out_green !== exp_res.green) begin
          $error("out_green: expected %0d, got %0d", exp_res.green, result_bus.out_green);
          error_count++;
        end
        if (result_bus.out_blue !== exp_res.blue) begin
          $error("out_blue: expected %0d, got %0d", exp_res.blue, result_bus.out_blue);
          error_count++;
        end
        if (result_bus.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, result_bus.status);
          error_count++;
        end
      end
    end
  end

  // Zero means one, anything above the store bound means the bound
  function automatic int unsigned effective_size(input logic [CFG_DATA_W-1:0] raw,
                                                 input int unsigned bound);
    if (raw == '0) return 1;
    if (raw > bound) return bound;
    return raw;
  endfunction

  // Scale Q3.12 coordinate by size-1, truncate, wrap into [0, size-2]
  function automatic int unsigned wrapped_index(input logic [COORD_W-1:0] coord,
                                                input int unsigned size);
    int span;
    int idx;
    span = int'(size) - 1;
    if (span <= 0) return 0;
    idx = (int'($signed(coord)) * span) / int'(Q_ONE);
    idx = idx % span;
    if (idx < 0) idx += span;
    return idx;
  endfunction

  // Advance the mirror by one item and return the texel it should produce
  function automatic texel_result_t apply_item(input sampler_req_t req);
    texel_result_t res;
    int unsigned   w;
    int unsigned   h;
    int unsigned   rx;
    int unsigned   ry;
    int unsigned   rw;
    int unsigned   rh;
    int unsigned   addr;
    logic [TEXEL_W-1:0] texel;
    res = '0;
    w = effective_size(width_reg, MAX_WIDTH_DEF);
    h = effective_size(height_reg, MAX_HEIGHT_DEF);
    if (req.cmd == CMD_SAMPLE) begin
      addr = wrapped_index(req.coord_v, h) * w + wrapped_index(req.coord_u, w);
      texel = texel_mem[addr];
      res.red   = texel[CHANNEL_BITS-1:0];
      res.green = texel[2*CHANNEL_BITS-1:CHANNEL_BITS];
      res.blue  = texel[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
      res.status = STATUS_SAMPLED;
    end else begin
      rx = req.region_x;
      ry = req.region_y;
      rw = req.region_w;
      rh = req.region_h;
      if (rw == 0 || rh == 0 || rx + rw > w || ry + rh > h) begin
        res.status = STATUS_REJECTED;
      end else begin
        // restart counters left over from a larger region
        if (fill_col >= rw || fill_row >= rh) begin
          fill_col = 0;
          fill_row = 0;
        end
        texel_mem[(ry + fill_row) * w + rx + fill_col] =
          {req.in_blue, req.in_green, req.in_red};
        fill_col++;
        if (fill_col >= rw) begin
          fill_col = 0;
          fill_row++;
          if (fill_row >= rh) fill_row = 0;
        end
        res.status = STATUS_WRITTEN;
      end
      if (req.region_last) begin
        fill_col = 0;
        fill_row = 0;
      end
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] random_coord();
    logic [COORD_W-1:0] edges [4];
    edges = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    if ($urandom_range(7) == 0) return edges[$urandom_range(3)];
    return COORD_W'($urandom);
  endfunction

  // Fully random item, both commands, all fields
  function automatic sampler_req_t random_req();
    sampler_req_t req;
    req.cmd         = CMD_W'($urandom);
    req.coord_u     = COORD_W'($urandom);
    req.coord_v     = COORD_W'($urandom);
    req.region_x    = REGION_POS_W'($urandom);
    req.region_y    = REGION_POS_W'($urandom);
    req.region_w    = REGION_SIZE_W'($urandom);
    req.region_h    = REGION_SIZE_W'($urandom);
    req.in_red      = CHANNEL_BITS'($urandom);
    req.in_green    = CHANNEL_BITS'($urandom);
    req.in_blue     = CHANNEL_BITS'($urandom);
    req.region_last = 1'($urandom);
    return req;
  endfunction

  function automatic sampler_req_t sample_req(input logic [COORD_W-1:0] u,
                                              input logic [COORD_W-1:0] v);
    sampler_req_t req;
    req = random_req();
    req.cmd     = CMD_SAMPLE;
    req.coord_u = u;
    req.coord_v = v;
    return req;
  endfunction

  function automatic sampler_req_t write_req(input int unsigned x, input int unsigned y,
                                             input int unsigned w, input int unsigned h,
                                             input logic [TEXEL_W-1:0] rgb, input bit last);
    sampler_req_t req;
    req = random_req();
    req.cmd         = CMD_WRITE;
    req.region_x    = REGION_POS_W'(x);
    req.region_y    = REGION_POS_W'(y);
    req.region_w    = REGION_SIZE_W'(w);
    req.region_h    = REGION_SIZE_W'(h);
    req.in_red      = rgb[CHANNEL_BITS-1:0];
    req.in_green    = rgb[2*CHANNEL_BITS-1:CHANNEL_BITS];
    req.in_blue     = rgb[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
    req.region_last = last;
    return req;
  endfunction

  // Offer one item after a random gap, record its expected texel on acceptance
  task automatic send_item(input sampler_req_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) @(negedge clk);
    item_bus.cmd         <= req.cmd;
    item_bus.coord_u     <= req.coord_u;
    item_bus.coord_v     <= req.coord_v;
    item_bus.region_x    <= req.region_x;
    item_bus.region_y    <= req.region_y;
    item_bus.region_w    <= req.region_w;
    item_bus.region_h    <= req.region_h;
    item_bus.in_red      <= req.in_red;
    item_bus.in_green    <= req.in_green;
    item_bus.in_blue     <= req.in_blue;
    item_bus.region_last <= req.region_last;
    item_bus.valid       <= 1'b1;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    expected_q.push_back(apply_item(req));
    @(negedge clk);
    item_bus.valid <= 1'b0;
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == CFG_IMAGE_WIDTH) width_reg = value;
    else if (idx == CFG_IMAGE_HEIGHT) height_reg = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Store must read back as zero after the clearing pass
  task automatic test_cleared_store();
    send_item(sample_req(16'h0000, 16'h0000));
    send_item(sample_req(16'h7FFF, 16'h8000));
  endtask

  // Fill a 2x2 region at the origin, then read it back with wrap in both directions
  task automatic test_region_fill();
    send_item(write_req(0, 0, 2, 2, 24'h0000FF, 1'b0));
    send_item(write_req(0, 0, 2, 2, 24'h00FF00, 1'b0));
    send_item(write_req(0, 0, 2, 2, 24'hFF0000, 1'b0));
    send_item(write_req(0, 0, 2, 2, 24'hFFFFFF, 1'b1));
    send_item(sample_req(16'h0000, 16'h0000));
    send_item(sample_req(16'd17, 16'd17));
    send_item(sample_req(-16'sd17, -16'sd17));
  endtask

  // Region flush against the far corner; last column and row stay unreachable
  task automatic test_corner_region();
    send_item(write_req(254, 254, 2, 2, 24'hA5A5A5, 1'b0));
    send_item(write_req(254, 254, 2, 2, 24'h5A5A5A, 1'b0));
    send_item(write_req(254, 254, 2, 2, 24'h123456, 1'b0));
    send_item(write_req(254, 254, 2, 2, 24'hFEDCBA, 1'b1));
    send_item(sample_req(-16'sd17, -16'sd17));
  endtask

  // Empty and overrunning regions, plus a full-size region that fits
  task automatic test_region_rejects();
    send_item(write_req(0, 0, 0, 4, 24'h111111, 1'b0));
    send_item(write_req(0, 0, 4, 0, 24'h222222, 1'b0));
    send_item(write_req(255, 0, 2, 1, 24'h333333, 1'b0));
    send_item(write_req(0, 1, 1, 256, 24'h444444, 1'b0));
    send_item(write_req(0, 0, 256, 256, 24'h555555, 1'b1));
  endtask

  // Too many texels wrap; counters carry into a new region until stale
  task automatic test_counter_edges();
    send_item(write_req(10, 10, 1, 2, 24'h0A0B0C, 1'b0));
    send_item(write_req(10, 10, 1, 2, 24'h1A1B1C, 1'b0));
    send_item(write_req(10, 10, 1, 2, 24'h2A2B2C, 1'b0));
    send_item(write_req(20, 20, 2, 2, 24'h3A3B3C, 1'b0));
    send_item(write_req(30, 30, 1, 1, 24'h4A4B4C, 1'b0));
    send_item(write_req(40, 40, 2, 2, 24'h5A5B5C, 1'b0));
    send_item(write_req(0, 0, 0, 0, 24'h6A6B6C, 1'b1));
  endtask

  // One image size: mostly well-formed regions and samples, some noise
  task automatic run_random_phase(input logic [CFG_DATA_W-1:0] cfg_w,
                                  input logic [CFG_DATA_W-1:0] cfg_h,
                                  input int unsigned n_items);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned rw;
    int unsigned rh;
    int unsigned rx;
    int unsigned ry;
    int unsigned texels;
    int unsigned pick;
    bit          broken;
    wait_for_results();
    write_register(CFG_IMAGE_WIDTH, cfg_w);
    write_register(CFG_IMAGE_HEIGHT, cfg_h);
    w = effective_size(cfg_w, MAX_WIDTH_DEF);
    h = effective_size(cfg_h, MAX_HEIGHT_DEF);
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_item(sample_req(random_coord(), random_coord()));
        sent++;
      end else if (pick < 85) begin
        rw = $urandom_range(1, (w < 6) ? w : 6);
        rh = $urandom_range(1, (h < 6) ? h : 6);
        rx = $urandom_range(0, w - rw);
        ry = $urandom_range(0, h - rh);
        texels = rw * rh;
        // occasionally cut the region short or run past its end without a last flag
        broken = ($urandom_range(7) == 0);
        if (broken) texels = $urandom_range(1, texels + 2);
        for (int unsigned k = 0; k < texels; k++) begin
          send_item(write_req(rx, ry, rw, rh, TEXEL_W'($urandom),
                              !broken && (k == texels - 1)));
        end
        sent += texels;
      end else begin
        send_item(random_req());
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    send_gap_pct   = 10;
    recv_stall_pct = 73;
    run_random_phase(9'd256, 9'd256, 80);
    run_random_phase(9'd1, 9'd1, 70);
    send_gap_pct   = 73;
    recv_stall_pct = 10;
    run_random_phase(9'd2, 9'd3, 80);
    run_random_phase(9'd0, 9'd511, 70);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random_phase(9'd20, 9'd12, 80);
    run_random_phase(9'd511, 9'd0, 70);
    run_random_phase(CFG_DATA_W'($urandom_range(3, 255)),
                     CFG_DATA_W'($urandom_range(3, 255)), 80);
  endtask

  // Hold off the result side long enough that the input stalls, then drain
  task automatic test_output_backpressure();
    wait_for_results();
    hold_len     = 400;
    hold_pending = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0) send_item(random_req());
      else send_item(sample_req(random_coord(), random_coord()));
    end
    wait_for_results();
  endtask

  initial begin
    rst            = 1'b1;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = '0;
    cfg_bus.data   = '0;
    item_bus.valid       = 1'b0;
    item_bus.cmd         = CMD_SAMPLE;
    item_bus.coord_u     = '0;
    item_bus.coord_v     = '0;
    item_bus.region_x    = '0;
    item_bus.region_y    = '0;
    item_bus.region_w    = '0;
    item_bus.region_h    = '0;
    item_bus.in_red      = '0;
    item_bus.in_green    = '0;
    item_bus.in_blue     = '0;
    item_bus.region_last = 1'b0;
    width_reg      = CFG_SIZE_RESET;
    height_reg     = CFG_SIZE_RESET;
    fill_col       = 0;
    fill_row       = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_len       = 0;
    hold_pending   = 1'b0;
    error_count    = 0;
    cycle_count    = 0;
    foreach (texel_mem[i]) texel_mem[i] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_cleared_store();
    test_region_fill();
    test_corner_region();
    test_region_rejects();
    test_counter_edges();
    test_random_traffic();
    test_output_backpressure();

    wait_for_results();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rtns_pkg.sv
rtl/rtns_cfg_if.sv
rtl/rtns_item_if.sv
rtl/rtns_result_if.sv
rtl/rtns_ram.sv
rtl/rgb_texture_nearest_sampler.sv
sim/tb_top.sv
